// ===== hdl/rfb_pkg.sv =====
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared constants, types and helpers for the rectangle fill framebuffer.
// ----------------------------------------------------------------------------
package rfb_pkg;

  localparam int MatrixShift = 3;
  localparam int MatrixSize  = 1 << MatrixShift;
  localparam int NumMatrices = 4;
  localparam int FrameLen    = NumMatrices * MatrixSize;
  localparam int AddrW       = $clog2(FrameLen);

  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic {
    OpDraw = 1'b0,
    OpRead = 1'b1
  } op_e;

  // Draw command handed to the span sequencer
  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] w;
    logic signed [7:0] h;
  } draw_cmd_t;

  // One span write request: OR mask into byte addr when vld and hit
  typedef struct packed {
    logic       vld;
    logic       hit;
    addr_t      addr;
    logic [7:0] mask;
  } span_req_t;

  // Quotient by the matrix size, truncated toward zero
  function automatic logic signed [15:0] sdiv_ms(input logic signed [15:0] v);
    logic [15:0] mag;
    logic [15:0] q;
    mag = v[15] ? 16'(-v) : 16'(v);
    q   = mag >> MatrixShift;
    return v[15] ? 16'(-q) : q;
  endfunction

  // Remainder by the matrix size, carrying the sign of the dividend
  function automatic logic signed [3:0] srem_ms(input logic signed [15:0] v);
    logic [15:0] mag;
    logic [3:0]  r;
    mag = v[15] ? 16'(-v) : 16'(v);
    r   = 4'(mag[MatrixShift-1:0]);
    return v[15] ? 4'(-r) : r;
  endfunction

endpackage

// ===== hdl/rfb_span_gen.sv =====
// ----------------------------------------------------------------------------
// rfb_span_gen
// Row and span sequencer: walks the rectangle one matrix byte per cycle and
// emits the byte index and run mask for each.
// ----------------------------------------------------------------------------
module rfb_span_gen (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rfb_pkg::draw_cmd_t cmd_i,
  output rfb_pkg::span_req_t req_o,
  output logic               busy_o
);
  import rfb_pkg::*;

  typedef enum logic [1:0] {
    GenIdle,
    GenSetup,
    GenRun
  } state_e;

  state_e state_q;
  draw_cmd_t cmd_q;

  logic signed [7:0]  xt_q;
  logic signed [15:0] mt_q;
  logic signed [3:0]  ntp_q;
  logic [5:0]         spans_q;
  logic               up_q;
  logic signed [15:0] cursor_x_q;
  logic signed [7:0]  cursor_y_q;
  logic [7:0]         rows_left_q;
  logic [5:0]         spans_left_q;

  // setup arithmetic
  logic signed [7:0]  xt;
  logic signed [15:0] x16;
  logic signed [15:0] mdiff;
  logic [15:0]        amdiff;
  logic [5:0]         spans;
  logic [7:0]         rows;

  // per-span arithmetic
  logic signed [15:0] m;
  logic signed [3:0]  np;
  logic signed [15:0] np16;
  logic [15:0]        dfull;
  logic [7:0]         d;
  logic               hi;
  logic               d_min;
  logic [7:0]         amag;
  logic [3:0]         cap;
  logic [8:0]         base9;
  logic [7:0]         base;
  logic signed [3:0]  sel;
  logic [4:0]         s5;
  logic [15:0]        shl;
  logic [7:0]         mask;
  logic [18:0]        idx;
  logic signed [15:0] cursor_x_nx;

  assign xt     = 8'(cmd_q.x + cmd_q.w);
  assign x16    = {{8{cmd_q.x[7]}}, cmd_q.x};
  assign mdiff  = 16'(sdiv_ms({{8{xt[7]}}, xt}) - sdiv_ms(x16));
  assign amdiff = mdiff[15] ? 16'(-mdiff) : 16'(mdiff);
  assign spans  = amdiff[5:0] + 6'd1;
  assign rows   = cmd_q.h[7] ? 8'(-cmd_q.h) : 8'(cmd_q.h);

  always_comb begin
    m     = sdiv_ms(cursor_x_q);
    np    = srem_ms(cursor_x_q);
    np16  = {{12{np[3]}}, np};
    dfull = 16'({{8{xt_q[7]}}, xt_q} - cursor_x_q);
    d     = dfull[7:0];
    hi    = ~d[7];
    d_min = (d == 8'h80);
    amag  = d[7] ? 8'(-d) : d;
    cap   = (amag > 8'd8) ? 4'd8 : amag[3:0];
    base9 = (9'd1 << cap) - 9'd1;
    base  = d_min ? 8'h00 : base9[7:0];
    sel   = hi ? ntp_q : np;
    s5    = 5'd8 - {sel[3], sel};
    shl   = {8'h00, base} << s5[3:0];
    if (m == mt_q) begin
      mask = shl[7:0];
    end else if (np[3]) begin
      mask = 8'h00;
    end else begin
      mask = base >> np[2:0];
    end
    idx = 19'({m, 3'b000}) + {{11{cursor_y_q[7]}}, cursor_y_q};
    cursor_x_nx = hi ? 16'(cursor_x_q + 16'sd8 - np16)
                     : 16'(cursor_x_q - 16'sd1 - np16);
  end

  always_comb begin
    req_o.vld  = (state_q == GenRun);
    req_o.hit  = ~idx[18] && (idx[17:0] < 18'(FrameLen));
    req_o.addr = idx[AddrW-1:0];
    req_o.mask = mask;
  end

  assign busy_o = (state_q != GenIdle);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == GenSetup) begin
      xt_q    <= xt;
      mt_q    <= sdiv_ms({{8{xt[7]}}, xt});
      ntp_q   <= srem_ms({{8{xt[7]}}, xt});
      spans_q <= spans;
      up_q    <= ~cmd_q.h[7] && (cmd_q.h != 8'sd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= GenIdle;
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      rows_left_q  <= '0;
      spans_left_q <= '0;
    end else begin
      unique case (state_q)
        GenIdle: begin
          if (start_i) begin
            state_q <= GenSetup;
          end
        end
        GenSetup: begin
          cursor_x_q   <= x16;
          cursor_y_q   <= cmd_q.y;
          rows_left_q  <= rows;
          spans_left_q <= spans;
          state_q      <= (rows == 8'd0) ? GenIdle : GenRun;
        end
        GenRun: begin
          if (spans_left_q == 6'd1) begin
            if (rows_left_q == 8'd1) begin
              // last span of last row: park cursors
              cursor_x_q   <= '0;
              cursor_y_q   <= '0;
              rows_left_q  <= '0;
              spans_left_q <= '0;
              state_q      <= GenIdle;
            end else begin
              rows_left_q  <= rows_left_q - 8'd1;
              cursor_y_q   <= up_q ? 8'(cursor_y_q + 8'sd1) : 8'(cursor_y_q - 8'sd1);
              cursor_x_q   <= {{8{cmd_q.x[7]}}, cmd_q.x};
              spans_left_q <= spans_q;
            end
          end else begin
            spans_left_q <= spans_left_q - 6'd1;
            cursor_x_q   <= cursor_x_nx;
          end
        end
        default: begin
          state_q <= GenIdle;
        end
      endcase
    end
  end

endmodule

// ===== hdl/rfb_rmw.sv =====
// ----------------------------------------------------------------------------
// rfb_rmw
// Framebuffer memory with registered reads, per-byte valid bits and a
// read-modify-write stage that ORs span masks in, forwarding back-to-back
// accesses to the same byte.
// ----------------------------------------------------------------------------
module rfb_rmw (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfb_pkg::span_req_t span_i,
  input  logic               rd_vld_i,
  input  rfb_pkg::addr_t     rd_addr_i,
  output logic [7:0]         rd_data_o,
  output logic               busy_o
);
  import rfb_pkg::*;

  logic [7:0]          mem_q [FrameLen];
  logic [FrameLen-1:0] vld_q;
  logic [7:0]          rdata_q;
  logic                rvld_q;

  logic       b_vld_q;
  addr_t      b_addr_q;
  logic [7:0] b_mask_q;
  logic       b_fwd_q;
  logic [7:0] b_fwd_data_q;

  logic       rd_en;
  addr_t      rd_addr;
  logic       wr_en;
  logic [7:0] old_data;
  logic [7:0] wr_data;

  assign rd_en    = (span_i.vld && span_i.hit) || rd_vld_i;
  assign rd_addr  = rd_vld_i ? rd_addr_i : span_i.addr;
  assign wr_en    = b_vld_q;
  // take the byte being written last cycle over the stale memory word
  assign old_data = b_fwd_q ? b_fwd_data_q : (rvld_q ? rdata_q : 8'h00);
  assign wr_data  = old_data | b_mask_q;

  assign rd_data_o = rvld_q ? rdata_q : 8'h00;
  assign busy_o    = b_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[b_addr_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    b_addr_q     <= span_i.addr;
    b_mask_q     <= span_i.mask;
    b_fwd_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      b_vld_q <= 1'b0;
      b_fwd_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[b_addr_q] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
      b_vld_q <= span_i.vld && span_i.hit;
      b_fwd_q <= wr_en && (b_addr_q == rd_addr);
    end
  end

endmodule

// ===== hdl/rectangle_fill_bitplane_top.sv =====
// ----------------------------------------------------------------------------
// rectangle_fill_bitplane_top
// Order: a read passes the registered memory read and StRead to StFinish;
//   a draw issues |rect_h| * spans writes, spans being the number
//   of matrix bytes one row of the rectangle touches (1 to 32).
// Throughput: one item at a time; the draw time is set by the single
//   framebuffer port, which takes one read-modify-write per cycle.
// Reset: clears the framebuffer valid bits (all bytes read as zero), the
//   sequencer and the handshake state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rectangle_fill_bitplane_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic signed [7:0] pos_x_i,
  input  logic signed [7:0] pos_y_i,
  input  logic signed [7:0] rect_w_i,
  input  logic signed [7:0] rect_h_i,
  input  logic [4:0]        read_addr_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic              done_res_o
);
  import rfb_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDraw,
    StRead,
    StFinish
  } state_e;

  state_e     state_q;
  logic [7:0] res_q;
  logic       out_vld_q;
  logic [7:0] out_data_q;
  logic       out_done_q;

  logic      accept;
  logic      rd_hit;
  logic      gen_start;
  logic      gen_busy;
  logic      rmw_busy;
  logic      rd_vld;
  logic      res_push;
  draw_cmd_t cmd;
  span_req_t span_req;
  logic [7:0] rd_data;

  // Take a new item only while idle; the output register holds the previous
  // result independently, so an unread result does not block acceptance.
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // Bytes past the end of the framebuffer read as zero without a memory access
  assign rd_hit    = 32'(read_addr_i) < 32'(FrameLen);
  assign gen_start = accept && (op_i == OpDraw);
  assign rd_vld    = accept && (op_i == OpRead) && rd_hit;

  // Present the finished item once the output register is free
  assign res_push = (state_q == StFinish) && (!out_vld_q || !out_stall_i);

  always_comb begin
    cmd.x = pos_x_i;
    cmd.y = pos_y_i;
    cmd.w = rect_w_i;
    cmd.h = rect_h_i;
  end

  rfb_span_gen u_span_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gen_start),
    .cmd_i   (cmd),
    .req_o   (span_req),
    .busy_o  (gen_busy)
  );

  rfb_rmw u_rmw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .span_i    (span_req),
    .rd_vld_i  (rd_vld),
    .rd_addr_i (AddrW'(read_addr_i)),
    .rd_data_o (rd_data),
    .busy_o    (rmw_busy)
  );

  assign out_valid_o = out_vld_q;
  assign read_data_o = out_data_q;
  assign done_res_o  = out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      res_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      out_done_q <= 1'b0;
    end else begin
      // load a finished result, or drop the held one once the consumer takes it
      if (res_push) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            res_q <= 8'h00;
            if (op_i == OpDraw) begin
              state_q <= StDraw;
            end else if (rd_hit) begin
              state_q <= StRead;
            end else begin
              state_q <= StFinish;
            end
          end
        end
        StDraw: begin
          // wait for the last span to issue and its write to retire
          if (!gen_busy && !rmw_busy) begin
            state_q <= StFinish;
          end
        end
        StRead: begin
          res_q   <= rd_data;
          state_q <= StFinish;
        end
        StFinish: begin
          // hold until the output register is free
          if (res_push) begin
            out_data_q <= res_q;
            out_done_q <= 1'b1;
            state_q    <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== hdl/rfb_checker.sv =====
// ----------------------------------------------------------------------------
// rfb_port_checks
// Port-level checks for the rectangle fill block, bound to the top level.
// ----------------------------------------------------------------------------
module rfb_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic       done_res_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("result changed while stalled");

  // every result reports completion
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> done_res_o)
    else $error("result without done flag");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while an item is in flight");

  // no result can appear in the cycle right after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind rectangle_fill_bitplane_top rfb_port_checks u_rfb_checker (.*);
